[hdl/two_axis_homing_sequencer_macros.svh]
// Assertion macros used by the homing sequencer checker.
`ifndef TWO_AXIS_HOMING_SEQUENCER_MACROS_SVH
`define TWO_AXIS_HOMING_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define THS_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define THS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[hdl/ths_pkg.sv]
// Codes and constants of the two-axis homing sequencer.
package ths_pkg;

   localparam int CSR_ADDR_WIDTH = 5;

   localparam logic [2:0] REG_LEAVE_DISP = 3'd0;
   localparam logic [2:0] REG_LEAVE_LOAD = 3'd1;
   localparam logic [2:0] REG_SEEK_DISP  = 3'd2;
   localparam logic [2:0] REG_SEEK_LOAD  = 3'd3;
   localparam logic [2:0] REG_READY_DISP = 3'd4;
   localparam logic [2:0] REG_MIN_MEET   = 3'd5;

   localparam int LEAVE_DISP_RESET = 1600;
   localparam int LEAVE_LOAD_RESET = -3200;
   localparam int SEEK_DISP_RESET  = 3200;
   localparam int SEEK_LOAD_RESET  = 12000;
   localparam int READY_DISP_RESET = 0;
   localparam int MIN_MEET_RESET   = 400;

   localparam logic [1:0] OP_RESET      = 2'd0;
   localparam logic [1:0] OP_RESET_RSP  = 2'd1;
   localparam logic [1:0] OP_DISP_DONE  = 2'd2;
   localparam logic [1:0] OP_LOAD_DONE  = 2'd3;

   localparam logic AXIS_DISP = 1'b0;
   localparam logic AXIS_LOAD = 1'b1;

   localparam logic [2:0] PH_IDLE        = 3'd0;
   localparam logic [2:0] PH_LEAVE       = 3'd1;
   localparam logic [2:0] PH_MEET        = 3'd2;
   localparam logic [2:0] PH_GOTO_SENSOR = 3'd3;
   localparam logic [2:0] PH_GOTO_READY  = 3'd4;

   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_REL   = 3'd1;
   localparam logic [2:0] KIND_SEEK  = 3'd2;
   localparam logic [2:0] KIND_SEEK2 = 3'd3;
   localparam logic [2:0] KIND_ABS   = 3'd4;

   localparam logic [1:0] SLIDE_NONE       = 2'd0;
   localparam logic [1:0] SLIDE_WATCH      = 2'd1;
   localparam logic [1:0] SLIDE_DISPATCHED = 2'd2;
   localparam logic [1:0] SLIDE_LOADED     = 2'd3;

endpackage

[hdl/two_axis_homing_sequencer.sv]
// Two-axis homing sequencer: phase control, command issue and CSR block.
//
//   channel  direction  handshake                     payload
//   req      in         req_tvalid / req_tready       req_tdata, req_tuser
//   rsp      out        rsp_tvalid / rsp_tready       rsp_tdata, rsp_tuser
//   csr      in         csr_psel, csr_penable, pready csr_paddr, csr_pwdata
//
// A word passes an input register, then one pass of phase logic, into the
// result register. One word per cycle while rsp does not stall.
// While a result waits, the input register can still take a word if it is empty; a
// stall on rsp holds both stages. Synchronous reset clears phase, axis flags,
// valids and the CSRs to their defaults.
module two_axis_homing_sequencer
   import ths_pkg::*;
#(
   parameter int POS_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // sensor_level, current_position, sensor_edge_position
   input  logic [((2*POS_WIDTH+1+7)/8)*8-1:0]     req_tdata,
   // opcode, axis_select
   input  logic [2:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // cmd_axis, cmd_value, all_homed, respond_success, slide_event
   output logic [((POS_WIDTH+5+7)/8)*8-1:0]       rsp_tdata,
   // cmd_kind
   output logic [2:0]                             rsp_tuser,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]              csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   localparam int RSP_DATA_WIDTH = ((POS_WIDTH+5+7)/8)*8;

   logic [POS_WIDTH-1:0] leave_disp_ff, leave_load_ff, ready_disp_ff;
   logic [POS_WIDTH-2:0] seek_disp_ff, seek_load_ff, min_meet_ff;
   logic                 csr_write;

   logic                 s1_valid_ff;
   logic [1:0]           s1_opcode_ff;
   logic                 s1_axis_ff;
   logic                 s1_level_ff;
   logic [POS_WIDTH-1:0] s1_cur_ff;
   logic [POS_WIDTH-1:0] s1_edge_ff;
   logic                 advance;

   logic [2:0]           phase_ff, phase_in;
   logic                 active_axis_ff, active_axis_in;
   logic [1:0]           axis_homed_ff, axis_homed_in;
   logic                 resp_pending_ff, resp_pending_in;

   logic [2:0]           kind;
   logic                 cmd_axis;
   logic [POS_WIDTH-1:0] cmd_value;
   logic                 resp;
   logic [1:0]           slide;
   logic                 on_sensor;
   logic                 done_axis;
   logic [POS_WIDTH:0]   diff;
   logic [POS_WIDTH:0]   meet_dist;
   logic                 meet_ok;
   logic [POS_WIDTH-1:0] leave_sel;
   logic [POS_WIDTH-1:0] seek_sel;
   logic [2:0]           seek_kind;
   logic [POS_WIDTH-1:0] ready_sel;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_kind_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         leave_disp_ff <= POS_WIDTH'(LEAVE_DISP_RESET);
         leave_load_ff <= POS_WIDTH'(LEAVE_LOAD_RESET);
         seek_disp_ff  <= (POS_WIDTH-1)'(SEEK_DISP_RESET);
         seek_load_ff  <= (POS_WIDTH-1)'(SEEK_LOAD_RESET);
         ready_disp_ff <= POS_WIDTH'(READY_DISP_RESET);
         min_meet_ff   <= (POS_WIDTH-1)'(MIN_MEET_RESET);
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_LEAVE_DISP: leave_disp_ff <= csr_pwdata[POS_WIDTH-1:0];
            REG_LEAVE_LOAD: leave_load_ff <= csr_pwdata[POS_WIDTH-1:0];
            REG_SEEK_DISP:  seek_disp_ff  <= csr_pwdata[POS_WIDTH-2:0];
            REG_SEEK_LOAD:  seek_load_ff  <= csr_pwdata[POS_WIDTH-2:0];
            REG_READY_DISP: ready_disp_ff <= csr_pwdata[POS_WIDTH-1:0];
            REG_MIN_MEET:   min_meet_ff   <= csr_pwdata[POS_WIDTH-2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_LEAVE_DISP: csr_prdata = 32'(leave_disp_ff);
         REG_LEAVE_LOAD: csr_prdata = 32'(leave_load_ff);
         REG_SEEK_DISP:  csr_prdata = 32'(seek_disp_ff);
         REG_SEEK_LOAD:  csr_prdata = 32'(seek_load_ff);
         REG_READY_DISP: csr_prdata = 32'(ready_disp_ff);
         REG_MIN_MEET:   csr_prdata = 32'(min_meet_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign advance    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_opcode_ff <= req_tuser[1:0];
         s1_axis_ff   <= req_tuser[2];
         s1_level_ff  <= req_tdata[0];
         s1_cur_ff    <= req_tdata[POS_WIDTH:1];
         s1_edge_ff   <= req_tdata[2*POS_WIDTH:POS_WIDTH+1];
      end
   end

   assign done_axis = s1_opcode_ff[0];
   assign diff      = {s1_edge_ff[POS_WIDTH-1], s1_edge_ff}
                    - {s1_cur_ff[POS_WIDTH-1], s1_cur_ff};
   assign meet_dist = diff[POS_WIDTH] ? (~diff + 1'b1) : diff;
   assign meet_ok   = meet_dist >= {2'b00, min_meet_ff};

   always_comb begin
      kind            = KIND_NONE;
      cmd_axis        = 1'b0;
      cmd_value       = '0;
      resp            = 1'b0;
      slide           = SLIDE_NONE;
      phase_in        = phase_ff;
      active_axis_in  = active_axis_ff;
      axis_homed_in   = axis_homed_ff;
      resp_pending_in = resp_pending_ff;
      on_sensor       = (s1_axis_ff == AXIS_LOAD) ? ~s1_level_ff : s1_level_ff;
      leave_sel       = (active_axis_ff == AXIS_LOAD) ? leave_load_ff : leave_disp_ff;
      seek_sel        = {1'b0, ((active_axis_ff == AXIS_LOAD) ? seek_load_ff
                                                              : seek_disp_ff)};
      seek_kind       = (active_axis_ff == AXIS_LOAD) ? KIND_SEEK : KIND_SEEK2;
      ready_sel       = (active_axis_ff == AXIS_LOAD) ? '0 : ready_disp_ff;
      if (advance) begin
         if (s1_opcode_ff == OP_RESET || s1_opcode_ff == OP_RESET_RSP) begin
            if (phase_ff == PH_IDLE) begin
               if (s1_opcode_ff == OP_RESET_RSP) begin
                  resp_pending_in = 1'b1;
               end
               slide                     = SLIDE_WATCH;
               axis_homed_in[s1_axis_ff] = 1'b0;
               active_axis_in            = s1_axis_ff;
               cmd_axis                  = s1_axis_ff;
               if (on_sensor) begin
                  phase_in  = PH_LEAVE;
                  kind      = KIND_REL;
                  cmd_value = (s1_axis_ff == AXIS_LOAD) ? leave_load_ff : leave_disp_ff;
               end else begin
                  phase_in  = PH_MEET;
                  kind      = (s1_axis_ff == AXIS_LOAD) ? KIND_SEEK : KIND_SEEK2;
                  cmd_value = {1'b0, ((s1_axis_ff == AXIS_LOAD) ? seek_load_ff
                                                                : seek_disp_ff)};
               end
            end
         end else if (done_axis == active_axis_ff) begin
            unique case (phase_ff)
               PH_LEAVE: begin
                  phase_in  = PH_GOTO_SENSOR;
                  kind      = seek_kind;
                  cmd_axis  = active_axis_ff;
                  cmd_value = seek_sel;
               end
               PH_MEET: begin
                  cmd_axis = active_axis_ff;
                  if (meet_ok) begin
                     phase_in  = PH_GOTO_READY;
                     kind      = KIND_ABS;
                     cmd_value = ready_sel;
                  end else begin
                     phase_in  = PH_LEAVE;
                     kind      = KIND_REL;
                     cmd_value = leave_sel;
                  end
               end
               PH_GOTO_SENSOR: begin
                  phase_in  = PH_GOTO_READY;
                  kind      = KIND_ABS;
                  cmd_axis  = active_axis_ff;
                  cmd_value = ready_sel;
               end
               PH_GOTO_READY: begin
                  axis_homed_in[active_axis_ff] = 1'b1;
                  phase_in = PH_IDLE;
                  slide    = (active_axis_ff == AXIS_LOAD) ? SLIDE_LOADED
                                                           : SLIDE_DISPATCHED;
                  if (resp_pending_ff) begin
                     resp_pending_in = 1'b0;
                     resp            = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         active_axis_ff  <= AXIS_DISP;
         axis_homed_ff   <= '0;
         resp_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         active_axis_ff  <= active_axis_in;
         axis_homed_ff   <= axis_homed_in;
         resp_pending_ff <= resp_pending_in;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff <= kind;
         rsp_data_ff <= RSP_DATA_WIDTH'({slide, resp, &axis_homed_in, cmd_value, cmd_axis});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

[hdl/ths_checker.sv]
// Port-level checks on the homing sequencer result channel, bound to the top.
`include "two_axis_homing_sequencer_macros.svh"

module ths_checker
   import ths_pkg::*;
#(
   parameter int POS_WIDTH = 24
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((POS_WIDTH+5+7)/8)*8-1:0]   rsp_tdata,
   input logic [2:0]                         rsp_tuser
);

   logic [1:0] slide;
   logic       resp;

   assign slide = rsp_tdata[POS_WIDTH+4:POS_WIDTH+3];
   assign resp  = rsp_tdata[POS_WIDTH+2];

   `THS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed under stall")

   `THS_ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_tvalid,
      rsp_tuser <= KIND_ABS, "cmd_kind out of range")

   `THS_ASSERT_IMPLY(a_resp_at_end, clock, reset, rsp_tvalid && resp,
      (slide == SLIDE_DISPATCHED || slide == SLIDE_LOADED) && rsp_tuser == KIND_NONE,
      "response answered outside end of homing")

   `THS_ASSERT_IMPLY(a_watch_cmd, clock, reset, rsp_tvalid && slide == SLIDE_WATCH,
      rsp_tuser == KIND_REL || rsp_tuser == KIND_SEEK || rsp_tuser == KIND_SEEK2,
      "homing start without a motion command")

endmodule

bind two_axis_homing_sequencer ths_checker #(.POS_WIDTH(POS_WIDTH)) u_ths_checker (.*);

[tb/tb_two_axis_homing_sequencer.sv]
// Self-checking stream testbench for the two-axis homing sequencer.
`timescale 1ns / 1ps

module tb_two_axis_homing_sequencer;
   import ths_pkg::*;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        axis;
      logic        level;
      logic [23:0] cur_pos;
      logic [23:0] edge_pos;
   } homing_event_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        axis;
      logic [23:0] value;
      logic        homed;
      logic        resp;
      logic [1:0]  slide;
   } homing_cmd_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // sensor_level, current_position, sensor_edge_position
   logic [2:0]  req_tuser;   // opcode, axis_select
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // cmd_axis, cmd_value, all_homed, respond_success, slide_event
   logic [2:0]  rsp_tuser;   // cmd_kind
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   two_axis_homing_sequencer #(.POS_WIDTH(24)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state and register shadow
   logic [23:0]   cfg [6];
   logic [2:0]    phase;
   logic          act_axis;
   logic [1:0]    homed;
   logic          rsp_pending;

   homing_event_type pending_words [$];
   homing_cmd_type   expected_cmds [$];
   int            mismatch_count;
   int            send_idle_pct;
   int            recv_idle_pct;
   bit            req_accepted;
   bit            send_hold;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic homing_cmd_type make_cmd(logic [2:0] kind, logic ax, logic [23:0] value);
      homing_cmd_type c;
      c = '0;
      c.kind = kind;
      c.axis = ax;
      c.value = value;
      return c;
   endfunction

   function automatic homing_cmd_type seek_cmd(logic ax);
      logic [23:0] lim;
      lim = {1'b0, (ax == AXIS_LOAD) ? cfg[REG_SEEK_LOAD][22:0] : cfg[REG_SEEK_DISP][22:0]};
      return make_cmd((ax == AXIS_LOAD) ? KIND_SEEK : KIND_SEEK2, ax, lim);
   endfunction

   function automatic homing_cmd_type ready_cmd(logic ax);
      return make_cmd(KIND_ABS, ax, (ax == AXIS_LOAD) ? 24'd0 : cfg[REG_READY_DISP]);
   endfunction

   function automatic homing_cmd_type leave_cmd(logic ax);
      return make_cmd(KIND_REL, ax,
                      (ax == AXIS_LOAD) ? cfg[REG_LEAVE_LOAD] : cfg[REG_LEAVE_DISP]);
   endfunction

   function automatic homing_cmd_type advance_homing(homing_event_type ev);
      homing_cmd_type o;
      logic        ax;
      logic        answered;
      longint      travel;
      o = '0;
      answered = 1'b0;
      if (ev.opcode == OP_RESET || ev.opcode == OP_RESET_RSP) begin
         if (phase == PH_IDLE) begin
            if (ev.opcode == OP_RESET_RSP) rsp_pending = 1'b1;
            homed[ev.axis] = 1'b0;
            act_axis = ev.axis;
            if ((ev.axis == AXIS_LOAD) ? !ev.level : ev.level) begin
               phase = PH_LEAVE;
               o = leave_cmd(ev.axis);
            end else begin
               phase = PH_MEET;
               o = seek_cmd(ev.axis);
            end
            o.slide = SLIDE_WATCH;
         end
      end else begin
         ax = (ev.opcode == OP_LOAD_DONE) ? AXIS_LOAD : AXIS_DISP;
         if (ax == act_axis) begin
            case (phase)
               PH_LEAVE: begin
                  phase = PH_GOTO_SENSOR;
                  o = seek_cmd(ax);
               end
               PH_MEET: begin
                  travel = longint'($signed(ev.edge_pos)) - longint'($signed(ev.cur_pos));
                  if (travel < 0) travel = -travel;
                  if (travel >= longint'(cfg[REG_MIN_MEET][22:0])) begin
                     phase = PH_GOTO_READY;
                     o = ready_cmd(ax);
                  end else begin
                     phase = PH_LEAVE;
                     o = leave_cmd(ax);
                  end
               end
               PH_GOTO_SENSOR: begin
                  phase = PH_GOTO_READY;
                  o = ready_cmd(ax);
               end
               PH_GOTO_READY: begin
                  homed[ax] = 1'b1;
                  phase = PH_IDLE;
                  o.slide = (ax == AXIS_LOAD) ? SLIDE_LOADED : SLIDE_DISPATCHED;
                  answered = rsp_pending;
                  rsp_pending = 1'b0;
               end
               default: ;
            endcase
         end
      end
      o.homed = homed[0] & homed[1];
      o.resp = answered;
      return o;
   endfunction

   // driver: present the next word, or idle
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_tvalid || req_accepted) begin
            req_accepted = 1'b0;
            if (pending_words.size() > 0 && !send_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               homing_event_type ev;
               ev = pending_words.pop_front();
               req_tdata  <= {7'd0, ev.edge_pos, ev.cur_pos, ev.level};
               req_tuser  <= {ev.axis, ev.opcode};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: predict on accept, check on result
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            homing_cmd_type act;
            homing_cmd_type exp_cmd;
            act.kind  = rsp_tuser;
            act.axis  = rsp_tdata[0];
            act.value = rsp_tdata[24:1];
            act.homed = rsp_tdata[25];
            act.resp  = rsp_tdata[26];
            act.slide = rsp_tdata[28:27];
            if (expected_cmds.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result kind=%0d axis=%0d value=%h", $realtime,
                           act.kind, act.axis, act.value);
            end else begin
               exp_cmd = expected_cmds.pop_front();
               if (act.kind !== exp_cmd.kind || act.axis !== exp_cmd.axis ||
                   act.value !== exp_cmd.value || act.homed !== exp_cmd.homed ||
                   act.resp !== exp_cmd.resp || act.slide !== exp_cmd.slide) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: mismatch kind %0d/%0d axis %0d/%0d value %h/%h ",
                               "homed %0d/%0d resp %0d/%0d slide %0d/%0d (exp/act)"},
                              $realtime, exp_cmd.kind, act.kind, exp_cmd.axis, act.axis,
                              exp_cmd.value, act.value, exp_cmd.homed, act.homed,
                              exp_cmd.resp, act.resp, exp_cmd.slide, act.slide);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            homing_event_type ev;
            ev.opcode   = req_tuser[1:0];
            ev.axis     = req_tuser[2];
            ev.level    = req_tdata[0];
            ev.cur_pos  = req_tdata[24:1];
            ev.edge_pos = req_tdata[48:25];
            expected_cmds.push_back(advance_homing(ev));
            req_accepted = 1'b1;
         end
      end
   end

   task automatic push_word(logic [1:0] op, logic ax, logic lvl, logic [23:0] cur,
                            logic [23:0] edge_p);
      homing_event_type ev;
      ev.opcode = op;
      ev.axis = ax;
      ev.level = lvl;
      ev.cur_pos = cur;
      ev.edge_pos = edge_p;
      pending_words.push_back(ev);
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_tvalid || expected_cmds.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [23:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {8'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg[idx] = (idx == REG_SEEK_DISP || idx == REG_SEEK_LOAD || idx == REG_MIN_MEET) ?
                 {1'b0, value[22:0]} : value;
   endtask

   // one homing attempt with random content, sometimes mixed with noise
   task automatic queue_homing_run();
      logic        ax;
      logic [23:0] edge_p;
      logic [23:0] offset;
      int          mm;
      int          n;
      ax = 1'($urandom_range(1));
      push_word($urandom_range(1) ? OP_RESET_RSP : OP_RESET, ax, 1'($urandom_range(1)),
                24'($urandom), 24'($urandom));
      n = $urandom_range(3, 8);
      mm = int'(cfg[REG_MIN_MEET]);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 12) begin
            push_word(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      24'($urandom), 24'($urandom));
         end else begin
            edge_p = 24'($urandom);
            case ($urandom_range(3))
               0: offset = 24'(mm + $urandom_range(4)) - 24'd2;
               1: offset = 24'($urandom_range(0, mm + 3));
               2: offset = 24'($urandom);
               default: offset = 24'(mm);
            endcase
            push_word(ax ? OP_LOAD_DONE : OP_DISP_DONE, ax, 1'($urandom_range(1)),
                      $urandom_range(1) ? edge_p + offset : edge_p - offset, edge_p);
         end
      end
   endtask

   initial begin
      int queued;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mismatch_count = 0;
      req_accepted = 1'b0;
      send_hold = 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 49;
      cfg[REG_LEAVE_DISP] = 24'(LEAVE_DISP_RESET);
      cfg[REG_LEAVE_LOAD] = 24'(LEAVE_LOAD_RESET);
      cfg[REG_SEEK_DISP]  = 24'(SEEK_DISP_RESET);
      cfg[REG_SEEK_LOAD]  = 24'(SEEK_LOAD_RESET);
      cfg[REG_READY_DISP] = 24'(READY_DISP_RESET);
      cfg[REG_MIN_MEET]   = 24'(MIN_MEET_RESET);
      phase = PH_IDLE;
      act_axis = AXIS_DISP;
      homed = 2'b00;
      rsp_pending = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed walk through every phase at the reset settings
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b1, 24'h800000, 24'h7FFFFF);
      push_word(OP_RESET, AXIS_DISP, 1'b1, 24'h7FFFFF, 24'h800000);
      push_word(OP_RESET_RSP, AXIS_LOAD, 1'b0, 24'd0, 24'd0);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b0, 24'd5, 24'd9000);
      push_word(OP_DISP_DONE, AXIS_DISP, 1'b0, 24'd0, 24'd0);
      push_word(OP_DISP_DONE, AXIS_DISP, 1'b1, 24'd100, 24'd0);
      push_word(OP_DISP_DONE, AXIS_DISP, 1'b0, 24'd0, 24'd0);
      push_word(OP_RESET_RSP, AXIS_LOAD, 1'b1, 24'd0, 24'd0);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b1, 24'd399, 24'd0);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b0, 24'd0, 24'd0);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b0, 24'd0, 24'd0);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b0, 24'd0, 24'd0);
      push_word(OP_RESET, AXIS_DISP, 1'b0, 24'd0, 24'd0);
      push_word(OP_DISP_DONE, AXIS_DISP, 1'b0, 24'd0, 24'd400);
      push_word(OP_DISP_DONE, AXIS_DISP, 1'b0, 24'd0, 24'd0);
      push_word(OP_RESET_RSP, AXIS_LOAD, 1'b0, 24'd0, 24'd0);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b0, 24'd0, 24'd0);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b0, 24'd0, 24'd0);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b0, 24'd0, 24'd0);
      push_word(OP_RESET, AXIS_DISP, 1'b0, 24'd0, 24'd0);
      push_word(OP_DISP_DONE, AXIS_DISP, 1'b1, 24'h800000, 24'h7FFFFF);
      push_word(OP_DISP_DONE, AXIS_DISP, 1'b0, 24'd0, 24'd0);
      push_word(OP_RESET, AXIS_LOAD, 1'b1, 24'd0, 24'd0);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b1, 24'h7FFFFF, 24'h800000);
      push_word(OP_LOAD_DONE, AXIS_LOAD, 1'b0, 24'd0, 24'd0);
      drain();

      for (int k = 0; k < 6; k++) begin
         send_idle_pct = (k < 2) ? 20 : (k < 4) ? 49 : 0;
         recv_idle_pct = (k < 2) ? 49 : (k < 4) ? 20 : 0;
         case (k)
            0: begin
               csr_write(REG_LEAVE_DISP, 24'h7FFFFF);
               csr_write(REG_LEAVE_LOAD, 24'h800000);
               csr_write(REG_SEEK_DISP, 24'd0);
               csr_write(REG_SEEK_LOAD, 24'h7FFFFF);
               csr_write(REG_READY_DISP, 24'h800000);
               csr_write(REG_MIN_MEET, 24'd0);
            end
            1: begin
               csr_write(REG_LEAVE_DISP, 24'h800000);
               csr_write(REG_LEAVE_LOAD, 24'h7FFFFF);
               csr_write(REG_SEEK_DISP, 24'h7FFFFF);
               csr_write(REG_SEEK_LOAD, 24'd0);
               csr_write(REG_READY_DISP, 24'h7FFFFF);
               csr_write(REG_MIN_MEET, 24'h7FFFFF);
            end
            default: begin
               csr_write(REG_LEAVE_DISP, 24'($urandom));
               csr_write(REG_LEAVE_LOAD, 24'($urandom));
               csr_write(REG_SEEK_DISP, 24'($urandom_range(0, 24'h7FFFFF)));
               csr_write(REG_SEEK_LOAD, 24'($urandom_range(0, 24'h7FFFFF)));
               csr_write(REG_READY_DISP, 24'($urandom));
               csr_write(REG_MIN_MEET, 24'(($urandom_range(3) == 0) ?
                         $urandom_range(0, 24'h7FFFFF) : $urandom_range(0, 2000)));
            end
         endcase
         queued = pending_words.size();
         while (pending_words.size() - queued < 140) queue_homing_run();
         // hold the sender mid-phase until every result is back
         if (k == 3) begin
            while (pending_words.size() > 70) @(posedge clock);
            send_hold = 1'b1;
            while (req_tvalid || expected_cmds.size() != 0) @(posedge clock);
            send_hold = 1'b0;
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
